[hdl/vrcr_pkg.sv]
`default_nettype none
package vrcr_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int SPAN_W     = 31;
  localparam int CH_W       = 8;
  localparam int COLOUR_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_LEFT   = 3'd0,
    REG_SCALE_SPAN   = 3'd1,
    REG_SCALE_MODE   = 3'd2,
    REG_LEFT_COLOUR  = 3'd3,
    REG_MID_COLOUR   = 3'd4,
    REG_RIGHT_COLOUR = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    MODE_TWO_POINT   = 1'b0,
    MODE_THREE_POINT = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_DIV  = 2'd2
  } cls_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] scale_left;
    logic [SPAN_W-1:0]   scale_span;
    mode_t               scale_mode;
    logic [COLOUR_W-1:0] left_colour;
    logic [COLOUR_W-1:0] mid_colour;
    logic [COLOUR_W-1:0] right_colour;
  } cfg_t;

endpackage
`default_nettype wire

[hdl/vrcr_if.sv]
`default_nettype none
interface vrcr_sample_if;
  logic                          valid;
  logic                          ready;
  logic [vrcr_pkg::SAMPLE_W-1:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface vrcr_rgba_if;
  logic                      valid;
  logic                      ready;
  logic [vrcr_pkg::CH_W-1:0] red;
  logic [vrcr_pkg::CH_W-1:0] green;
  logic [vrcr_pkg::CH_W-1:0] blue;
  logic [vrcr_pkg::CH_W-1:0] alpha;
  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);
endinterface

interface vrcr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vrcr_pkg::CFG_IDX_W-1:0]  index;
  logic [vrcr_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/value_to_rgba_colour_ramp.sv]
// Maps a stream of signed Q16.16 samples to RGBA colours along a two-point
// or three-point linear ramp.
// The sample channel takes one word per cycle when ready is high, and the
// rgba channel returns one colour word for every sample word, in order.
// The config channel is always ready and writes data into the register at
// index; it should only be used while no sample is in flight.
// From sample acceptance to rgba valid, one stage forms and clamps the
// offset, one restoring divider stage per fraction bit produces the quotient,
// one stage picks the colour pair and weight, and one stage runs the
// per-channel multiply and round.
// One sample per cycle unless rgba stalls, as the divider is fully pipelined.
// Reset empties the pipeline and loads the default scale and colours.
// When the receiver stalls, each stage holds its word and bubbles ahead of it
// still fill, so the sample channel keeps accepting until the pipeline is full.
`default_nettype none
module value_to_rgba_colour_ramp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  vrcr_sample_if.sink sample,
  vrcr_rgba_if.source rgba,
  vrcr_cfg_if.sink    cfg
);

  vrcr_pkg::cfg_t              regs;
  logic                        f_valid;
  vrcr_pkg::cls_t              f_cls;
  logic [vrcr_pkg::SPAN_W-1:0] f_rem;
  logic                        f_ready;
  logic                        d_valid;
  vrcr_pkg::cls_t              d_cls;
  logic [FRAC_BITS-1:0]        d_quo;
  logic                        d_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.scale_left   <= '0;
      regs.scale_span   <= 31'd65536;
      regs.scale_mode   <= vrcr_pkg::MODE_TWO_POINT;
      regs.left_colour  <= 32'hFFFF_FFFF;
      regs.mid_colour   <= 32'h8080_80FF;
      regs.right_colour <= 32'h0000_FFFF;
    end else if (cfg.valid) begin
      case (vrcr_pkg::cfg_reg_t'(cfg.index))
        vrcr_pkg::REG_SCALE_LEFT:   regs.scale_left   <= cfg.data;
        vrcr_pkg::REG_SCALE_SPAN:   regs.scale_span   <= cfg.data[vrcr_pkg::SPAN_W-1:0];
        vrcr_pkg::REG_SCALE_MODE:   regs.scale_mode   <= vrcr_pkg::mode_t'(cfg.data[0]);
        vrcr_pkg::REG_LEFT_COLOUR:  regs.left_colour  <= cfg.data;
        vrcr_pkg::REG_MID_COLOUR:   regs.mid_colour   <= cfg.data;
        vrcr_pkg::REG_RIGHT_COLOUR: regs.right_colour <= cfg.data;
        default: ;
      endcase
    end
  end

  vrcr_frac u_frac (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .cfg       (regs),
    .out_valid (f_valid),
    .out_cls   (f_cls),
    .out_rem   (f_rem),
    .out_ready (f_ready)
  );

  vrcr_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .span      (regs.scale_span),
    .in_valid  (f_valid),
    .in_cls    (f_cls),
    .in_rem    (f_rem),
    .in_ready  (f_ready),
    .out_valid (d_valid),
    .out_cls   (d_cls),
    .out_quo   (d_quo),
    .out_ready (d_ready)
  );

  vrcr_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk      (clk),
    .rst      (rst),
    .cfg      (regs),
    .in_valid (d_valid),
    .in_cls   (d_cls),
    .in_quo   (d_quo),
    .in_ready (d_ready),
    .rgba     (rgba)
  );

endmodule
`default_nettype wire

[hdl/vrcr_frac.sv]
`default_nettype none
module vrcr_frac (
  input  wire logic                          clk,
  input  wire logic                          rst,
  vrcr_sample_if.sink                        sample,
  input  wire vrcr_pkg::cfg_t                cfg,
  output logic                               out_valid,
  output vrcr_pkg::cls_t                     out_cls,
  output logic [vrcr_pkg::SPAN_W-1:0]        out_rem,
  input  wire logic                          out_ready
);

  logic [vrcr_pkg::SAMPLE_W:0] diff;
  logic                        at_zero;
  logic                        at_one;
  logic                        en;
  vrcr_pkg::cls_t              cls_next;
  logic [vrcr_pkg::SPAN_W-1:0] rem_next;

  assign diff = {sample.sample_value[vrcr_pkg::SAMPLE_W-1], sample.sample_value}
              - {cfg.scale_left[vrcr_pkg::SAMPLE_W-1], cfg.scale_left};
  assign at_zero = (cfg.scale_span == '0) || diff[vrcr_pkg::SAMPLE_W] || (diff == '0);
  assign at_one  = diff[vrcr_pkg::SAMPLE_W-1:0] >= {1'b0, cfg.scale_span};

  always_comb begin
    cls_next = vrcr_pkg::CLS_DIV;
    rem_next = diff[vrcr_pkg::SPAN_W-1:0];
    if (at_zero) begin
      cls_next = vrcr_pkg::CLS_ZERO;
      rem_next = '0;
    end else if (at_one) begin
      cls_next = vrcr_pkg::CLS_ONE;
      rem_next = '0;
    end
  end

  assign en = !out_valid || out_ready;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cls <= cls_next;
      out_rem <= rem_next;
    end
  end

  a_div_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_cls == vrcr_pkg::CLS_DIV) |-> out_rem != '0)
    else $error("divide word enters with a zero remainder");

  a_end_rem_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_cls != vrcr_pkg::CLS_DIV) |-> out_rem == '0)
    else $error("clamped word carries a remainder");

endmodule
`default_nettype wire

[hdl/vrcr_divider.sv]
`default_nettype none
module vrcr_divider #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [vrcr_pkg::SPAN_W-1:0]   span,
  input  wire logic                          in_valid,
  input  wire vrcr_pkg::cls_t                in_cls,
  input  wire logic [vrcr_pkg::SPAN_W-1:0]   in_rem,
  output logic                               in_ready,
  output logic                               out_valid,
  output vrcr_pkg::cls_t                     out_cls,
  output logic [FRAC_BITS-1:0]               out_quo,
  input  wire logic                          out_ready
);

  logic                        v   [FRAC_BITS];
  logic                        en  [FRAC_BITS];
  vrcr_pkg::cls_t              cls [FRAC_BITS];
  logic [vrcr_pkg::SPAN_W-1:0] rem [FRAC_BITS];
  logic [FRAC_BITS-1:0]        quo [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
    logic                        s_v;
    vrcr_pkg::cls_t              s_cls;
    logic [vrcr_pkg::SPAN_W-1:0] s_rem;
    logic [FRAC_BITS-1:0]        s_quo;
    logic                        s_rdy;
    logic [vrcr_pkg::SPAN_W:0]   twice;
    logic                        ge;
    logic                        vld;
    vrcr_pkg::cls_t              cls_q;
    logic [vrcr_pkg::SPAN_W-1:0] rem_q;
    logic [FRAC_BITS-1:0]        quo_q;

    if (k == 0) begin : g_first
      assign s_v   = in_valid;
      assign s_cls = in_cls;
      assign s_rem = in_rem;
      assign s_quo = '0;
    end else begin : g_rest
      assign s_v   = v[k-1];
      assign s_cls = cls[k-1];
      assign s_rem = rem[k-1];
      assign s_quo = quo[k-1];
    end

    if (k == FRAC_BITS - 1) begin : g_last
      assign s_rdy = out_ready;
    end else begin : g_mid
      assign s_rdy = en[k+1];
    end

    assign en[k] = !vld || s_rdy;
    assign twice = {s_rem, 1'b0};
    assign ge    = (s_cls == vrcr_pkg::CLS_DIV) && (twice >= {1'b0, span});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (en[k]) begin
        vld <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        cls_q <= s_cls;
        quo_q <= {s_quo[FRAC_BITS-2:0], ge};
        if (ge) begin
          rem_q <= vrcr_pkg::SPAN_W'(twice - {1'b0, span});
        end else begin
          rem_q <= twice[vrcr_pkg::SPAN_W-1:0];
        end
      end
    end

    assign v[k]   = vld;
    assign cls[k] = cls_q;
    assign rem[k] = rem_q;
    assign quo[k] = quo_q;
  end

  assign in_ready  = en[0];
  assign out_valid = v[FRAC_BITS-1];
  assign out_cls   = cls[FRAC_BITS-1];
  assign out_quo   = quo[FRAC_BITS-1];

  a_clamped_no_quotient: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_cls != vrcr_pkg::CLS_DIV) |-> out_quo == '0)
    else $error("clamped word picked up quotient bits");

endmodule
`default_nettype wire

[hdl/vrcr_blend.sv]
`default_nettype none
module vrcr_blend #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire vrcr_pkg::cfg_t     cfg,
  input  wire logic               in_valid,
  input  wire vrcr_pkg::cls_t     in_cls,
  input  wire logic [FRAC_BITS-1:0] in_quo,
  output logic                    in_ready,
  vrcr_rgba_if.source             rgba
);

  localparam int AW = FRAC_BITS + 9;
  localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

  logic [FRAC_BITS:0]            t;
  logic [FRAC_BITS:0]            t_off;
  logic [FRAC_BITS:0]            g_next;
  logic [vrcr_pkg::COLOUR_W-1:0] c0_next;
  logic [vrcr_pkg::COLOUR_W-1:0] c1_next;
  logic                          en1;
  logic                          en2;
  logic                          v1;
  logic [FRAC_BITS:0]            g;
  logic [vrcr_pkg::COLOUR_W-1:0] c0;
  logic [vrcr_pkg::COLOUR_W-1:0] c1;
  logic [vrcr_pkg::COLOUR_W-1:0] colour_next;
  logic                          v2;
  logic [vrcr_pkg::COLOUR_W-1:0] colour;

  always_comb begin
    case (in_cls)
      vrcr_pkg::CLS_ONE: t = ONE;
      vrcr_pkg::CLS_DIV: t = {1'b0, in_quo};
      default:           t = '0;
    endcase
  end

  assign t_off = t - HALF;

  always_comb begin
    g_next  = t;
    c0_next = cfg.left_colour;
    c1_next = cfg.right_colour;
    if (cfg.scale_mode == vrcr_pkg::MODE_THREE_POINT) begin
      if (t < HALF) begin
        g_next  = {t[FRAC_BITS-1:0], 1'b0};
        c1_next = cfg.mid_colour;
      end else begin
        g_next  = {t_off[FRAC_BITS-1:0], 1'b0};
        c0_next = cfg.mid_colour;
      end
    end
  end

  always_comb begin
    logic [AW-1:0] p0;
    logic [AW-1:0] p1;
    logic [AW-1:0] acc;
    colour_next = '0;
    for (int k = 0; k < 4; k++) begin
      p0  = {{(AW-vrcr_pkg::CH_W){1'b0}}, c0[vrcr_pkg::CH_W*k +: vrcr_pkg::CH_W]}
          * {{(AW-FRAC_BITS-1){1'b0}}, ONE - g};
      p1  = {{(AW-vrcr_pkg::CH_W){1'b0}}, c1[vrcr_pkg::CH_W*k +: vrcr_pkg::CH_W]}
          * {{(AW-FRAC_BITS-1){1'b0}}, g};
      acc = p0 + p1 + {{(AW-FRAC_BITS-1){1'b0}}, HALF};
      colour_next[vrcr_pkg::CH_W*k +: vrcr_pkg::CH_W] = acc[FRAC_BITS +: vrcr_pkg::CH_W];
    end
  end

  assign en2      = !v2 || rgba.ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      g  <= g_next;
      c0 <= c0_next;
      c1 <= c1_next;
    end
    if (en2) begin
      colour <= colour_next;
    end
  end

  assign rgba.valid = v2;
  assign rgba.red   = colour[31:24];
  assign rgba.green = colour[23:16];
  assign rgba.blue  = colour[15:8];
  assign rgba.alpha = colour[7:0];

  a_weight_in_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> g <= ONE)
    else $error("blend weight above one");

endmodule
`default_nettype wire
